// ===== hdl/slv_pkg.sv =====
package slv_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int UNIT_FRAC_BITS_DEF = 15;
  localparam int NUM_AXES           = 3;

endpackage

// ===== hdl/segment_length_and_unit_vector.sv =====
// Segment difference, length and unit vector.
// Input: start and end points (in_start_*, in_end_*, signed Q8.8 by default)
// are transferred at a rising edge with start high and busy low. busy is
// always low, so one item is taken every clock cycle.
// Output: out_valid strobes for one cycle with end minus start (out_diff_*),
// floor of the Euclidean length (out_seg_length), the unit vector
// (out_unit_*, truncated toward zero, saturated at +/- full scale) and
// out_zero_length for coincident points, where the unit vector is zero.
// The pipeline has registers for difference, squares and sum, one square
// root cell per root bit (COORD_BITS + 1), a divider setup register, one
// divider cell per fraction bit, and the output register. Throughput is
// one item per cycle; every cell hands its work to the next on each clock.
// The receiver cannot stall; results are presented once and not held.
// Reset clears only the valid pipeline; no result appears from data
// that was in flight at reset.
module segment_length_and_unit_vector
  import slv_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  output logic                        out_valid,
  output logic signed [COORD_BITS:0]   out_diff_x,
  output logic signed [COORD_BITS:0]   out_diff_y,
  output logic signed [COORD_BITS:0]   out_diff_z,
  output logic [COORD_BITS:0]          out_seg_length,
  output logic signed [UNIT_FRAC_BITS:0] out_unit_x,
  output logic signed [UNIT_FRAC_BITS:0] out_unit_y,
  output logic signed [UNIT_FRAC_BITS:0] out_unit_z,
  output logic                        out_zero_length
);

  localparam int C   = COORD_BITS;
  localparam int F   = UNIT_FRAC_BITS;
  localparam int DW  = C + 1;
  localparam int LW  = C + 1;
  localparam int SB  = 2 * C + 2;
  localparam int NS  = C + 1;
  localparam int SRW = C + 4;
  localparam int DRW = C + 2;
  localparam int UW  = F + 1;
  localparam int SW  = NUM_AXES * DW;
  localparam int DSW = SW + NUM_AXES + 1;
  localparam int LAT = NS + F + 5;

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  logic signed [DW-1:0] s1_d_r   [NUM_AXES];
  logic signed [DW-1:0] s2_d_r   [NUM_AXES];
  logic [SB-1:0]        s2_sq_r  [NUM_AXES];
  logic signed [DW-1:0] s3_d_r   [NUM_AXES];
  logic [SB-1:0]        s3_sum_r;

  logic signed [C-1:0]  st [NUM_AXES];
  logic signed [C-1:0]  en [NUM_AXES];
  logic [DW-1:0]        s2_mag [NUM_AXES];

  logic [SB-1:0]  sr_rad  [0:NS];
  logic [SRW-1:0] sr_rem  [0:NS];
  logic [LW-1:0]  sr_root [0:NS];
  logic [SW-1:0]  sr_side [0:NS];

  logic [NUM_AXES-1:0][DRW-1:0] dv_rem  [0:F];
  logic [NUM_AXES-1:0][F-1:0]   dv_q    [0:F];
  logic [LW-1:0]                dv_len  [0:F];
  logic [DSW-1:0]               dv_side [0:F];

  logic [NUM_AXES-1:0][DRW-1:0] s4_rem_nxt;
  logic [NUM_AXES-1:0]          s4_top_nxt;
  logic [DW-1:0]                s4_mag [NUM_AXES];
  logic [NUM_AXES-1:0][DRW-1:0] s4_rem_r;
  logic [LW-1:0]                s4_len_r;
  logic [DSW-1:0]               s4_side_r;

  logic signed [DW-1:0] od [NUM_AXES];
  logic [NUM_AXES-1:0]  otop;
  logic                 ozero;
  logic signed [UW-1:0] ounit [NUM_AXES];
  logic [UW-1:0]        oq    [NUM_AXES];

  logic signed [DW-1:0] out_d_r    [NUM_AXES];
  logic signed [UW-1:0] out_unit_r [NUM_AXES];
  logic [LW-1:0]        out_len_r;
  logic                 out_zero_r;

  assign busy = 1'b0;

  assign st[0] = in_start_x;
  assign st[1] = in_start_y;
  assign st[2] = in_start_z;
  assign en[0] = in_end_x;
  assign en[1] = in_end_y;
  assign en[2] = in_end_z;

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s2_mag[a] = s1_d_r[a][DW-1] ? DW'(-s1_d_r[a]) : DW'(s1_d_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s1_d_r[a]  <= DW'(en[a]) - DW'(st[a]);
      s2_d_r[a]  <= s1_d_r[a];
      s2_sq_r[a] <= SB'(s2_mag[a] * s2_mag[a]);
      s3_d_r[a]  <= s2_d_r[a];
    end
    s3_sum_r <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
  end

  assign sr_rad[0]  = s3_sum_r;
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_side[0] = {s3_d_r[0], s3_d_r[1], s3_d_r[2]};

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    slv_sqrt_cell #(
      .NW(SB), .RW(SRW), .QW(LW), .SIDE_W(SW)
    ) u_cell (
      .clk    (clk),
      .rad_i  (sr_rad[k]),
      .rem_i  (sr_rem[k]),
      .root_i (sr_root[k]),
      .side_i (sr_side[k]),
      .rad_o  (sr_rad[k+1]),
      .rem_o  (sr_rem[k+1]),
      .root_o (sr_root[k+1]),
      .side_o (sr_side[k+1])
    );
  end

  // the length is never below a component magnitude: equality is the
  // quotient's integer bit, handled here before the fraction cells
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s4_mag[a] = sr_side[NS][(NUM_AXES-1-a)*DW+DW-1] ?
                  DW'(-sr_side[NS][(NUM_AXES-1-a)*DW +: DW]) :
                  sr_side[NS][(NUM_AXES-1-a)*DW +: DW];
      s4_top_nxt[a] = (s4_mag[a] == sr_root[NS]);
      s4_rem_nxt[a] = s4_top_nxt[a] ? '0 : DRW'(s4_mag[a]);
    end
  end

  always_ff @(posedge clk) begin
    s4_rem_r  <= s4_rem_nxt;
    s4_len_r  <= sr_root[NS];
    s4_side_r <= {sr_side[NS], s4_top_nxt, (sr_root[NS] == '0)};
  end

  assign dv_rem[0]  = s4_rem_r;
  assign dv_q[0]    = '0;
  assign dv_len[0]  = s4_len_r;
  assign dv_side[0] = s4_side_r;

  for (genvar k = 0; k < F; k++) begin : g_div
    slv_div_cell #(
      .RW(DRW), .LW(LW), .QW(F), .SIDE_W(DSW)
    ) u_cell (
      .clk    (clk),
      .rem_i  (dv_rem[k]),
      .q_i    (dv_q[k]),
      .len_i  (dv_len[k]),
      .side_i (dv_side[k]),
      .rem_o  (dv_rem[k+1]),
      .q_o    (dv_q[k+1]),
      .len_o  (dv_len[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  // saturate a full-scale ratio, force zero for a zero-length segment
  always_comb begin
    ozero = dv_side[F][0];
    otop  = dv_side[F][NUM_AXES:1];
    for (int a = 0; a < NUM_AXES; a++) begin
      od[a]    = dv_side[F][NUM_AXES+1+(NUM_AXES-1-a)*DW +: DW];
      oq[a]    = otop[a] ? {1'b0, {F{1'b1}}} : {1'b0, dv_q[F][a]};
      ounit[a] = ozero ? '0 : (od[a][DW-1] ? UW'(-oq[a]) : UW'(oq[a]));
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      out_d_r[a]    <= od[a];
      out_unit_r[a] <= ounit[a];
    end
    out_len_r  <= dv_len[F];
    out_zero_r <= ozero;
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_diff_x      = out_d_r[0];
  assign out_diff_y      = out_d_r[1];
  assign out_diff_z      = out_d_r[2];
  assign out_seg_length  = out_len_r;
  assign out_unit_x      = out_unit_r[0];
  assign out_unit_y      = out_unit_r[1];
  assign out_unit_z      = out_unit_r[2];
  assign out_zero_length = out_zero_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item did not produce a result on time");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_length == (out_seg_length == '0)))
    else $error("zero_length disagrees with seg_length");

  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0 &&
       out_diff_x == '0 && out_diff_y == '0 && out_diff_z == '0))
    else $error("zero-length segment with nonzero vector");

endmodule

// ===== hdl/slv_sqrt_cell.sv =====
module slv_sqrt_cell
  import slv_pkg::*;
#(
  parameter int NW     = 34,
  parameter int RW     = 20,
  parameter int QW     = 17,
  parameter int SIDE_W = 51
) (
  input  logic              clk,
  input  logic [NW-1:0]     rad_i,
  input  logic [RW-1:0]     rem_i,
  input  logic [QW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [NW-1:0]     rad_o,
  output logic [RW-1:0]     rem_o,
  output logic [QW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic              ge;
  logic [NW-1:0]     rad_nxt;
  logic [RW-1:0]     rem_nxt;
  logic [QW-1:0]     root_nxt;
  logic [NW-1:0]     rad_r;
  logic [RW-1:0]     rem_r;
  logic [QW-1:0]     root_r;
  logic [SIDE_W-1:0] side_r;

  // bring down the next pair of radicand bits, try root*4+1
  always_comb begin
    rem_sh   = {rem_i[RW-3:0], rad_i[NW-1:NW-2]};
    trial    = RW'({root_i, 2'b01});
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[QW-2:0], ge};
    rad_nxt  = {rad_i[NW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= side_i;
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// ===== hdl/slv_div_cell.sv =====
module slv_div_cell
  import slv_pkg::*;
#(
  parameter int RW     = 18,
  parameter int LW     = 17,
  parameter int QW     = 15,
  parameter int SIDE_W = 55
) (
  input  logic                         clk,
  input  logic [NUM_AXES-1:0][RW-1:0]  rem_i,
  input  logic [NUM_AXES-1:0][QW-1:0]  q_i,
  input  logic [LW-1:0]                len_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic [NUM_AXES-1:0][RW-1:0]  rem_o,
  output logic [NUM_AXES-1:0][QW-1:0]  q_o,
  output logic [LW-1:0]                len_o,
  output logic [SIDE_W-1:0]            side_o
);

  logic [NUM_AXES-1:0][RW-1:0] sh;
  logic [NUM_AXES-1:0]         ge;
  logic [NUM_AXES-1:0][RW-1:0] rem_nxt;
  logic [NUM_AXES-1:0][QW-1:0] q_nxt;
  logic [NUM_AXES-1:0][RW-1:0] rem_r;
  logic [NUM_AXES-1:0][QW-1:0] q_r;
  logic [LW-1:0]               len_r;
  logic [SIDE_W-1:0]           side_r;

  // one restoring quotient bit per axis; remainder stays below len
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sh[a]      = {rem_i[a][RW-2:0], 1'b0};
      ge[a]      = (sh[a] >= RW'(len_i));
      rem_nxt[a] = ge[a] ? (sh[a] - RW'(len_i)) : sh[a];
      q_nxt[a]   = {q_i[a][QW-2:0], ge[a]};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    len_r  <= len_i;
    side_r <= side_i;
  end

  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign len_o  = len_r;
  assign side_o = side_r;

endmodule
